// ===== sv/lpht_pkg.sv =====
// Shared types and constants for the linear probing hash table.
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int KEY_BYTES   = 8;

  // Slot index width; slots are a power of two so the home slot is the hash's low bits.
  localparam int SLOT_W    = $clog2(TABLE_SLOTS);
  localparam int CNT_W     = $clog2(TABLE_SLOTS);
  localparam int KEY_W     = 64;
  localparam int KEY_LEN_W = 4;
  localparam int DATA_W    = 64;
  localparam int FLAG_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int RESP_IDX_W = 6;

  localparam logic [63:0] HASH_SEED  = 64'd5381;
  localparam int          HASH_SHIFT = 5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [KEY_W-1:0]     key_value;
    logic [KEY_LEN_W-1:0] key_length;
    logic [DATA_W-1:0]    data_in;
    logic [FLAG_W-1:0]    flag_in;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [RESP_IDX_W-1:0] slot_index;
    logic [DATA_W-1:0]     data_out;
    logic [FLAG_W-1:0]     flag_out;
  } resp_t;

  // One table entry as stored in the slot memory.
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [KEY_LEN_W-1:0] key_len;
    logic [DATA_W-1:0]    data;
    logic [FLAG_W-1:0]    flag;
  } slot_t;

endpackage

// ===== sv/lpht_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/lpht_hash.sv =====
// Key canonicalization and djb2 home slot (only the low index bits are kept).
`timescale 1ns / 1ps

module lpht_hash (
  input  logic [lpht_pkg::KEY_W-1:0]     raw_key,
  input  logic [lpht_pkg::KEY_LEN_W-1:0] raw_len,
  output logic [lpht_pkg::KEY_W-1:0]     key,
  output logic [lpht_pkg::KEY_LEN_W-1:0] key_len,
  output logic [lpht_pkg::SLOT_W-1:0]    home
);
  import lpht_pkg::*;

  logic [KEY_LEN_W-1:0] lim;

  assign lim = (raw_len > KEY_LEN_W'(KEY_BYTES)) ? KEY_LEN_W'(KEY_BYTES) : raw_len;

  // h*33+b mod 2^k only depends on the low k bits of h, so the hash runs narrow.
  always_comb begin : canon_hash
    logic              alive;
    logic [SLOT_W-1:0] h;
    logic [7:0]        b;
    alive   = 1'b1;
    h       = SLOT_W'(HASH_SEED);
    key     = '0;
    key_len = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = raw_key[8*i +: 8];
      if (alive && (KEY_LEN_W'(i) < lim) && (b != 8'd0)) begin
        key[8*i +: 8] = b;
        key_len       = KEY_LEN_W'(i + 1);
        h             = h + (h << HASH_SHIFT) + SLOT_W'(b);
      end else begin
        alive = 1'b0;
      end
    end
    home = h;
  end

endmodule

// ===== sv/linear_probe_hash_table_unit.sv =====
// Top level: request sequencer, slot valid bits and slot memory of the hash table.
//
// Usage: one request transaction on req (insert or search) gives exactly one
// response transaction on resp. A transaction moves at a clock edge where valid
// is high and stall is low. Requests are handled one at a time: req_stall is high
// from acceptance until the response is loaded into the output register.
// The sequencer passes through S_HASH and then S_PROBE for each probed slot,
// starting at the home slot. An insert decides each probe from the valid bits
// alone; a search that meets an occupied slot reads the slot memory, whose read
// port is registered, and compares the key in S_CMP. Probing ends at the first
// empty slot, at a key match, or once every slot has been probed.
// Reset (synchronous, active high) clears all slot valid bits at once, so the
// table is empty and usable on the next cycle; no clearing pass is needed.
// While resp_stall is high the response is held stable; a finished request waits
// in its final state and no further request is taken until the response register
// can be refilled.
`timescale 1ns / 1ps

module linear_probe_hash_table_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  lpht_pkg::req_t   req,
  output logic             resp_valid,
  input  logic             resp_stall,
  output lpht_pkg::resp_t  resp
);
  import lpht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  state_t               state;
  req_t                 req_r;
  logic [KEY_W-1:0]     key_c;
  logic [KEY_LEN_W-1:0] len_c;
  logic [SLOT_W-1:0]    probe_idx;
  logic [CNT_W-1:0]     probe_cnt;
  logic                 slot_valid [TABLE_SLOTS];
  resp_t                res_r;

  logic [KEY_W-1:0]     hash_key;
  logic [KEY_LEN_W-1:0] hash_len;
  logic [SLOT_W-1:0]    hash_home;

  logic                 ram_we;
  logic                 ram_re;
  slot_t                ram_wdata;
  logic [$bits(slot_t)-1:0] ram_rdata;
  slot_t                rd_slot;

  logic [SLOT_W-1:0]    idx_next;
  logic                 last_probe;
  logic                 hit;
  logic                 empty_slot;
  logic                 resp_load;

  lpht_hash u_hash (
    .raw_key (req_r.key_value),
    .raw_len (req_r.key_length),
    .key     (hash_key),
    .key_len (hash_len),
    .home    (hash_home)
  );

  lpht_ram #(
    .DEPTH (TABLE_SLOTS),
    .WIDTH ($bits(slot_t))
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (probe_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (probe_idx),
    .rdata (ram_rdata)
  );

  assign req_stall  = (state != S_IDLE);
  assign rd_slot    = slot_t'(ram_rdata);
  assign empty_slot = !slot_valid[probe_idx];
  assign hit        = (rd_slot.key_len == len_c) && (rd_slot.key == key_c);
  assign idx_next   = (probe_idx == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : probe_idx + 1'b1;
  assign last_probe = (probe_cnt == CNT_W'(TABLE_SLOTS - 1));
  // load the output register once it is free or being emptied
  assign resp_load  = (state == S_DONE) && (!resp_valid || !resp_stall);

  always_comb begin
    ram_we    = (state == S_PROBE) && empty_slot && (req_r.req_type == REQ_INSERT);
    ram_re    = (state == S_PROBE) && !empty_slot && (req_r.req_type == REQ_SEARCH);
    ram_wdata = '{key: key_c, key_len: len_c, data: req_r.data_in, flag: req_r.flag_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      resp_valid <= 1'b0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else begin
      if (resp_load) begin
        resp       <= res_r;
        resp_valid <= 1'b1;
      end else if (resp_valid && !resp_stall) begin
        resp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_r <= req;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          key_c     <= hash_key;
          len_c     <= hash_len;
          probe_idx <= hash_home;
          probe_cnt <= '0;
          state     <= S_PROBE;
        end
        S_PROBE: begin
          if (empty_slot) begin
            if (req_r.req_type == REQ_INSERT) begin
              slot_valid[probe_idx] <= 1'b1;
              res_r <= '{status: ST_OK, slot_index: RESP_IDX_W'(probe_idx),
                         data_out: '0, flag_out: '0};
            end else begin
              res_r <= '{status: ST_NOT_FOUND, slot_index: '0, data_out: '0, flag_out: '0};
            end
            state <= S_DONE;
          end else if (req_r.req_type == REQ_SEARCH) begin
            state <= S_CMP;
          end else if (last_probe) begin
            res_r <= '{status: ST_FULL, slot_index: '0, data_out: '0, flag_out: '0};
            state <= S_DONE;
          end else begin
            probe_idx <= idx_next;
            probe_cnt <= probe_cnt + 1'b1;
          end
        end
        S_CMP: begin
          if (hit) begin
            res_r <= '{status: ST_OK, slot_index: RESP_IDX_W'(probe_idx),
                       data_out: rd_slot.data, flag_out: rd_slot.flag};
            state <= S_DONE;
          end else if (last_probe) begin
            res_r <= '{status: ST_FULL, slot_index: '0, data_out: '0, flag_out: '0};
            state <= S_DONE;
          end else begin
            probe_idx <= idx_next;
            probe_cnt <= probe_cnt + 1'b1;
            state     <= S_PROBE;
          end
        end
        S_DONE: begin
          if (resp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> (resp.status == ST_OK || resp.status == ST_NOT_FOUND ||
                    resp.status == ST_FULL))
    else $error("response carries an undefined status code");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (resp_valid && resp.status != ST_OK) |->
      (resp.slot_index == '0 && resp.data_out == '0 && resp.flag_out == '0))
    else $error("not-found or full response has nonzero payload");

  a_insert_marks_valid: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> slot_valid[$past(probe_idx)])
    else $error("slot written without being marked valid");

  a_cmp_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> $past(ram_re))
    else $error("key compare without a slot read in the previous cycle");

endmodule
